// ===== rtl/nec_ir_edge_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder_macros
// Assertion macros for the infrared edge decoder; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_EDGE_DECODER_MACROS_SVH
`define NEC_IR_EDGE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define NECIR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define NECIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define NECIR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define NECIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// Shared constants and types of the infrared edge decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package necir_pkg;

   // default configuration
   localparam int FRAME_BITS_DEFAULT = 32;
   localparam int TIME_WIDTH_DEFAULT = 16;

   // port widths
   localparam int ELAPSED_BITS = 16;
   localparam int KEY_BITS     = 32;

   // leader mark that restarts the decoder, inclusive window
   localparam logic [15:0] LONG_MARK_MIN = 16'd7000;
   localparam logic [15:0] LONG_MARK_MAX = 16'd11000;

   // leader space windows while idle, open windows
   localparam logic [15:0] START_SPACE_LO  = 16'd4000;
   localparam logic [15:0] START_SPACE_HI  = 16'd5000;
   localparam logic [15:0] REPEAT_SPACE_LO = 16'd2000;
   localparam logic [15:0] REPEAT_SPACE_HI = 16'd2500;

   // nominal leader check for a press, open windows
   localparam logic [15:0] NOM_MARK_LO  = 16'd8700;
   localparam logic [15:0] NOM_MARK_HI  = 16'd9300;
   localparam logic [15:0] NOM_SPACE_LO = 16'd4200;
   localparam logic [15:0] NOM_SPACE_HI = 16'd4800;

   // data space limits
   localparam logic [15:0] BIT_SPACE_MIN = 16'd360;
   localparam logic [15:0] BIT_ONE_ABOVE = 16'd1480;
   localparam logic [15:0] BIT_SPACE_MAX = 16'd1880;

   // timing classes of one edge interval
   typedef struct packed {
      logic long_mark;     // 7000 to 11000
      logic mark_nominal;  // leader mark near 9000
      logic space_nominal; // leader space near 4500
      logic start_space;   // frame start leader space
      logic repeat_space;  // repeat leader space
      logic bit_one;       // data space coding a one
      logic bit_bad;       // data space out of range
   } timing_type;

endpackage

// ===== rtl/necir_timing.sv =====
// ----------------------------------------------------------------------------
// necir_timing
// Compares one edge interval against all timing windows of the protocol.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module necir_timing #(
   parameter int TIME_BITS = 16
) (
   input  logic [TIME_BITS-1:0] interval,
   output necir_pkg::timing_type timing
);

   logic [15:0] t;

   assign t = 16'(interval);

   // window compares
   always_comb begin
      timing.long_mark     = (t >= necir_pkg::LONG_MARK_MIN) && (t <= necir_pkg::LONG_MARK_MAX);
      timing.mark_nominal  = (t > necir_pkg::NOM_MARK_LO) && (t < necir_pkg::NOM_MARK_HI);
      timing.space_nominal = (t > necir_pkg::NOM_SPACE_LO) && (t < necir_pkg::NOM_SPACE_HI);
      timing.start_space   = (t > necir_pkg::START_SPACE_LO) && (t < necir_pkg::START_SPACE_HI);
      timing.repeat_space  = (t > necir_pkg::REPEAT_SPACE_LO) && (t < necir_pkg::REPEAT_SPACE_HI);
      timing.bit_bad       = (t < necir_pkg::BIT_SPACE_MIN) || (t > necir_pkg::BIT_SPACE_MAX);
      timing.bit_one       = (t > necir_pkg::BIT_ONE_ABOVE) && (t <= necir_pkg::BIT_SPACE_MAX);
   end

endmodule

// ===== rtl/nec_ir_edge_decoder.sv =====
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder
// Edge-driven decoder for NEC infrared remote frames.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per edge of the demodulated receiver line;
//     req_edge_rising is 1 when a mark ends, 0 when a space ends, and
//     req_elapsed_us is the time since the previous edge.
//   rsp channel: zero or one beat per edge; rsp_key_code carries the frame
//     (first received bit in bit zero) and rsp_key_repeat is 1 for a repeat
//     code carrying the last good key.
//   Path: a beat is held in the input register and decoded into the
//     result register once that register is free or being read, so a
//     result is registered after its edge was accepted.
//   Throughput: one edge per cycle while rsp is not stalled; the decode is one pass of window
//     compares and a one-bit shift between the two registers.
//   Stall: while a result waits on rsp_ready, one more edge is taken into
//     the input register, after which req_ready drops until rsp is free.
//   Reset: clears the frame state, the last key (a repeat before any press
//     returns zero) and both registers' valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nec_ir_edge_decoder_macros.svh"

module nec_ir_edge_decoder #(
   parameter int FRAME_BITS = necir_pkg::FRAME_BITS_DEFAULT,
   parameter int TIME_WIDTH = necir_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_edge_rising,
   input  logic [necir_pkg::ELAPSED_BITS-1:0] req_elapsed_us,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [necir_pkg::KEY_BITS-1:0]     rsp_key_code,
   output logic                               rsp_key_repeat
);

   localparam int TimeBits  = (TIME_WIDTH < necir_pkg::ELAPSED_BITS) ?
                              TIME_WIDTH : necir_pkg::ELAPSED_BITS;
   localparam int CountBits = $clog2(FRAME_BITS + 1);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_rising_ff;
   logic [TimeBits-1:0]   in_time_ff;

   // frame state
   logic [CountBits-1:0]  sym_ff, sym_in;
   logic                  mark_ok_ff, mark_ok_in;
   logic                  space_ok_ff, space_ok_in;
   logic [FRAME_BITS-1:0] shift_ff, shift_in;
   logic                  bad_ff, bad_in;
   logic [FRAME_BITS-1:0] last_key_ff, last_key_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [FRAME_BITS-1:0] out_key_ff, out_key_in;
   logic                  out_repeat_ff, out_repeat_in;

   logic                  advance;
   logic                  emit;
   logic                  frame_done;
   necir_pkg::timing_type timing;

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid      = out_valid_ff;
   assign rsp_key_code   = necir_pkg::KEY_BITS'(out_key_ff);
   assign rsp_key_repeat = out_repeat_ff;

   // window compares on the held interval
   necir_timing #(
      .TIME_BITS(TimeBits)
   ) u_timing (
      .interval(in_time_ff),
      .timing  (timing)
   );

   assign frame_done = (sym_ff == CountBits'(FRAME_BITS));

   // decode of one edge against the frame state
   always_comb begin
      sym_in        = sym_ff;
      mark_ok_in    = mark_ok_ff;
      space_ok_in   = space_ok_ff;
      shift_in      = shift_ff;
      bad_in        = bad_ff;
      last_key_in   = last_key_ff;
      emit          = 1'b0;
      out_key_in    = out_key_ff;
      out_repeat_in = out_repeat_ff;
      if (advance) begin
         if (in_rising_ff) begin
            // end of a mark
            if (timing.long_mark) begin
               mark_ok_in = timing.mark_nominal;
               sym_in     = '0;
            end else if (sym_ff == '0) begin
               mark_ok_in = timing.mark_nominal;
            end
         end else if (sym_ff == '0) begin
            // leader space while idle
            space_ok_in = timing.space_nominal;
            if (timing.start_space) begin
               sym_in   = CountBits'(1);
               shift_in = '0;
               bad_in   = 1'b0;
            end else if (timing.repeat_space) begin
               emit          = 1'b1;
               out_key_in    = last_key_ff;
               out_repeat_in = 1'b1;
            end
         end else begin
            // data space
            bad_in   = bad_ff || timing.bit_bad;
            shift_in = {timing.bit_one, shift_ff[FRAME_BITS-1:1]};
            sym_in   = sym_ff + CountBits'(1);
            if (frame_done) begin
               sym_in = '0;
               if (!bad_in && mark_ok_ff && space_ok_ff) begin
                  last_key_in   = shift_in;
                  emit          = 1'b1;
                  out_key_in    = shift_in;
                  out_repeat_in = 1'b0;
               end
            end
         end
      end
   end

   // valid flags of both registers
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sym_ff       <= '0;
         mark_ok_ff   <= 1'b0;
         space_ok_ff  <= 1'b0;
         shift_ff     <= '0;
         bad_ff       <= 1'b0;
         last_key_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sym_ff       <= sym_in;
         mark_ok_ff   <= mark_ok_in;
         space_ok_ff  <= space_ok_in;
         shift_ff     <= shift_in;
         bad_ff       <= bad_in;
         last_key_ff  <= last_key_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_rising_ff <= req_edge_rising;
         in_time_ff   <= req_elapsed_us[TimeBits-1:0];
      end
      out_key_ff    <= out_key_in;
      out_repeat_ff <= out_repeat_in;
   end

   // checks
   `NECIR_ASSERT_IMP(a_sym_range, clock, reset, 1'b1,
      sym_ff <= CountBits'(FRAME_BITS), "symbol count beyond frame length")
   `NECIR_ASSERT_IMP(a_repeat_idle, clock, reset, emit && out_repeat_in,
      sym_ff == '0, "repeat result outside idle")
   `NECIR_ASSERT_NEXT(a_press_key, clock, reset, emit && !out_repeat_in,
      rsp_valid && (rsp_key_code == necir_pkg::KEY_BITS'(last_key_ff)),
      "press result does not match last key")
   `NECIR_ASSERT_IMP(a_stall_full, clock, reset, !req_ready,
      in_valid_ff && out_valid_ff && !rsp_ready, "input stalled without cause")
   `NECIR_ASSERT_IMP(a_emit_free, clock, reset, emit,
      !out_valid_ff || rsp_ready, "result loaded over a waiting result")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Edge-level test of the NEC infrared decoder. Directed window boundaries come
// first, then random NEC frames, repeat codes, broken frames and line noise.
// Every accepted edge goes through a cycle-free decoder model in the
// scoreboard. Every key beat is compared with the oldest predicted key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAME_LEN   = necir_pkg::FRAME_BITS_DEFAULT;
   localparam int EDGE_TARGET = 1600;

   typedef struct packed {
      logic [necir_pkg::KEY_BITS-1:0] code;
      logic                           is_repeat;
   } key_beat_type;

   // decoder model and queue of predicted key beats
   class nec_key_scoreboard;
      logic [5:0]                     symbol_count;
      logic [15:0]                    leader_mark;
      logic [15:0]                    leader_space;
      logic [necir_pkg::KEY_BITS-1:0] bit_shift;
      logic                           frame_bad;
      logic [necir_pkg::KEY_BITS-1:0] last_key;
      key_beat_type                   pending_keys[$];
      int                             errors;

      function new();
         symbol_count = '0;
         leader_mark  = '0;
         leader_space = '0;
         bit_shift    = '0;
         frame_bad    = 1'b0;
         last_key     = '0;
         errors       = 0;
      endfunction

      // returns 1 when the edge is not ignored by the decoder
      function bit note_edge(logic rising, logic [15:0] us);
         logic one;
         key_beat_type beat;
         one = 1'b0;
         if (rising) begin
            // a long mark always restarts, other marks count only while idle
            if (us >= necir_pkg::LONG_MARK_MIN && us <= necir_pkg::LONG_MARK_MAX) begin
               leader_mark  = us;
               symbol_count = '0;
               return 1'b1;
            end
            if (symbol_count == 0) begin
               leader_mark = us;
               return 1'b1;
            end
            return 1'b0;
         end
         // leader space while idle
         if (symbol_count == 0) begin
            leader_space = us;
            if (us > necir_pkg::START_SPACE_LO && us < necir_pkg::START_SPACE_HI) begin
               symbol_count = 6'd1;
               bit_shift    = '0;
               frame_bad    = 1'b0;
            end else if (us > necir_pkg::REPEAT_SPACE_LO &&
                         us < necir_pkg::REPEAT_SPACE_HI) begin
               beat.code      = last_key;
               beat.is_repeat = 1'b1;
               pending_keys.push_back(beat);
            end
            return 1'b1;
         end
         // data space, first bit ends up in bit zero
         if (us < necir_pkg::BIT_SPACE_MIN || us > necir_pkg::BIT_SPACE_MAX)
            frame_bad = 1'b1;
         else if (us > necir_pkg::BIT_ONE_ABOVE)
            one = 1'b1;
         bit_shift    = {one, bit_shift[necir_pkg::KEY_BITS-1:1]};
         symbol_count = symbol_count + 6'd1;
         if (symbol_count >= FRAME_LEN + 1) begin
            symbol_count = '0;
            if (!frame_bad &&
                leader_mark > necir_pkg::NOM_MARK_LO &&
                leader_mark < necir_pkg::NOM_MARK_HI &&
                leader_space > necir_pkg::NOM_SPACE_LO &&
                leader_space < necir_pkg::NOM_SPACE_HI) begin
               last_key       = bit_shift;
               beat.code      = bit_shift;
               beat.is_repeat = 1'b0;
               pending_keys.push_back(beat);
            end
         end
         return 1'b1;
      endfunction

      function void check_key(logic [necir_pkg::KEY_BITS-1:0] code, logic is_repeat);
         key_beat_type want;
         if (pending_keys.size() == 0) begin
            $error("unexpected key beat: key_code %h key_repeat %0b", code, is_repeat);
            errors++;
            return;
         end
         want = pending_keys.pop_front();
         if (code !== want.code) begin
            $error("key_code: expected %h, actual %h", want.code, code);
            errors++;
         end
         if (is_repeat !== want.is_repeat) begin
            $error("key_repeat: expected %0b, actual %0b", want.is_repeat, is_repeat);
            errors++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_edge_rising = 1'b0;
   logic [necir_pkg::ELAPSED_BITS-1:0] req_elapsed_us = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [necir_pkg::KEY_BITS-1:0]     rsp_key_code;
   logic                               rsp_key_repeat;

   nec_key_scoreboard keys_sb = new();

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int edges_used    = 0;

   nec_ir_edge_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_edge_rising (req_edge_rising),
      .req_elapsed_us  (req_elapsed_us),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_code    (rsp_key_code),
      .rsp_key_repeat  (rsp_key_repeat)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check each beat, stall at random or for a long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         keys_sb.check_key(rsp_key_code, rsp_key_repeat);
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // one edge beat, with random idle cycles ahead of it
   task automatic drive_edge(input logic rising, input logic [15:0] us);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_edge_rising <= rising;
      req_elapsed_us  <= us;
      do @(posedge clock); while (!req_ready);
      void'(keys_sb.note_edge(rising, us));
      edges_used++;
   endtask

   // leader mark, mostly near 9000 but also on the window edges
   function automatic logic [15:0] pick_leader_mark();
      unique case ($urandom_range(0, 9))
         0: return necir_pkg::NOM_MARK_LO;
         1: return necir_pkg::NOM_MARK_HI;
         2: return $urandom_range(0, 1) ? necir_pkg::LONG_MARK_MIN
                                        : necir_pkg::LONG_MARK_MAX;
         3: return 16'($urandom_range(necir_pkg::LONG_MARK_MIN, necir_pkg::LONG_MARK_MAX));
         default: return 16'($urandom_range(necir_pkg::NOM_MARK_LO + 1,
                                            necir_pkg::NOM_MARK_HI - 1));
      endcase
   endfunction

   // leader space that starts a frame, mostly near 4500
   function automatic logic [15:0] pick_leader_space();
      unique case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? necir_pkg::NOM_SPACE_LO
                                        : necir_pkg::NOM_SPACE_HI;
         1: return 16'($urandom_range(0, 1) ? necir_pkg::START_SPACE_LO + 1
                                            : necir_pkg::START_SPACE_HI - 1);
         2: return 16'($urandom_range(necir_pkg::START_SPACE_LO + 1,
                                      necir_pkg::START_SPACE_HI - 1));
         default: return 16'($urandom_range(necir_pkg::NOM_SPACE_LO + 1,
                                            necir_pkg::NOM_SPACE_HI - 1));
      endcase
   endfunction

   // mark between data spaces, never inside the long mark window
   function automatic logic [15:0] pick_bit_mark();
      if ($urandom_range(0, 9) != 0)
         return 16'($urandom_range(460, 660));
      return 16'($urandom_range(0, 1) ? $urandom_range(0, necir_pkg::LONG_MARK_MIN - 1)
                 : $urandom_range(necir_pkg::LONG_MARK_MAX + 1, 16'hFFFF));
   endfunction

   function automatic logic [15:0] pick_data_space(logic one);
      if ($urandom_range(0, 7) == 0) begin
         if (one)
            return 16'($urandom_range(0, 1) ? necir_pkg::BIT_ONE_ABOVE + 1
                                            : necir_pkg::BIT_SPACE_MAX);
         return $urandom_range(0, 1) ? necir_pkg::BIT_SPACE_MIN
                                     : necir_pkg::BIT_ONE_ABOVE;
      end
      return 16'(one ? $urandom_range(necir_pkg::BIT_ONE_ABOVE + 1, necir_pkg::BIT_SPACE_MAX)
                     : $urandom_range(necir_pkg::BIT_SPACE_MIN, necir_pkg::BIT_ONE_ABOVE));
   endfunction

   // full frame; bad_at puts one space out of range, cut_at breaks it off
   task automatic send_frame(input int bad_at, input int cut_at);
      logic [necir_pkg::KEY_BITS-1:0] data;
      logic [15:0]                    space;
      int                             i;
      data = $urandom();
      drive_edge(1'b1, pick_leader_mark());
      drive_edge(1'b0, pick_leader_space());
      for (i = 0; i < FRAME_LEN; i++) begin
         if (i == cut_at) begin
            drive_edge(1'b1, 16'($urandom_range(necir_pkg::LONG_MARK_MIN,
                                                necir_pkg::LONG_MARK_MAX)));
            return;
         end
         drive_edge(1'b1, pick_bit_mark());
         if (i == bad_at)
            space = 16'($urandom_range(0, 1)
                        ? $urandom_range(0, necir_pkg::BIT_SPACE_MIN - 1)
                        : $urandom_range(necir_pkg::BIT_SPACE_MAX + 1, 16'hFFFF));
         else
            space = pick_data_space(data[i]);
         drive_edge(1'b0, space);
      end
   endtask

   task automatic send_repeat_code();
      drive_edge(1'b1, pick_leader_mark());
      drive_edge(1'b0, 16'($urandom_range(necir_pkg::REPEAT_SPACE_LO + 1,
                                          necir_pkg::REPEAT_SPACE_HI - 1)));
   endtask

   // stimulus and end of run
   initial begin
      int roll;
      int n;
      int wait_cycles;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // window boundaries and special cases, no idling
      drive_edge(1'b0, 16'd2001);   // repeat before any press gives zero
      drive_edge(1'b0, necir_pkg::REPEAT_SPACE_LO);
      drive_edge(1'b0, 16'd2499);
      drive_edge(1'b0, necir_pkg::REPEAT_SPACE_HI);
      drive_edge(1'b1, 16'd0);
      drive_edge(1'b1, 16'hFFFF);
      drive_edge(1'b0, 16'd0);
      drive_edge(1'b0, 16'hFFFF);
      drive_edge(1'b0, necir_pkg::START_SPACE_LO);
      drive_edge(1'b0, necir_pkg::START_SPACE_HI);
      drive_edge(1'b1, 16'd6999);
      drive_edge(1'b1, 16'd11001);
      drive_edge(1'b0, 16'd4001);   // frame start
      drive_edge(1'b1, 16'd12000);  // ordinary mark ignored inside a frame
      drive_edge(1'b0, 16'd359);    // out of range, frame marked bad
      drive_edge(1'b0, necir_pkg::BIT_SPACE_MIN);
      drive_edge(1'b0, necir_pkg::BIT_ONE_ABOVE);
      drive_edge(1'b0, 16'd1481);
      drive_edge(1'b0, necir_pkg::BIT_SPACE_MAX);
      drive_edge(1'b0, 16'd1881);
      drive_edge(1'b1, necir_pkg::LONG_MARK_MIN);  // long mark abandons the frame
      drive_edge(1'b0, 16'd4999);
      drive_edge(1'b1, necir_pkg::LONG_MARK_MAX);
      drive_edge(1'b0, 16'd2499);

      // long receiver hold-off while repeat codes keep coming
      rsp_hold_left = 300;
      repeat (24) send_repeat_code();

      // random frames, repeats, broken frames and noise over four phases of idling and stalling
      while (edges_used < EDGE_TARGET) begin
         unique case (edges_used * 4 / EDGE_TARGET)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 68; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 55)
            send_frame(-1, -1);
         else if (roll < 65)
            send_frame($urandom_range(0, FRAME_LEN - 1), -1);
         else if (roll < 72)
            send_frame(-1, $urandom_range(0, FRAME_LEN - 1));
         else if (roll < 87)
            send_repeat_code();
         else begin
            n = $urandom_range(1, 6);
            repeat (n) drive_edge(1'($urandom_range(0, 1)),
                                  16'($urandom_range(0, 16'hFFFF)));
         end
      end
      req_valid <= 1'b0;

      // drain the remaining keys, then wait for late beats
      wait_cycles = 0;
      while (keys_sb.pending_keys.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (keys_sb.pending_keys.size() != 0) begin
         $error("%0d predicted key beats never arrived", keys_sb.pending_keys.size());
         keys_sb.errors++;
      end
      if (keys_sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hard limit on the run
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/necir_pkg.sv
rtl/necir_timing.sv
rtl/nec_ir_edge_decoder.sv
test/tb_top.sv
